### hw/rtl/wsfc_pkg.sv
// Shared types and constants for the WebAssembly section framing checker.
// Depends on nothing; every other file in hw/rtl imports it.
package wsfc_pkg;

  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ID_W    = 4;

  // Highest legal section id
  localparam logic [BYTE_W-1:0] MAX_SECTION_ID = 8'd13;

  // Module header: magic "\0asm" followed by version 1, little endian
  localparam logic [BYTE_W-1:0] MAGIC [8] = '{
    8'h00, 8'h61, 8'h73, 8'h6D, 8'h01, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ACCEPT     = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_ID     = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_TRUNC      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ID      = 2'd1,
    PH_SIZE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

endpackage

### hw/rtl/wsfc_if.sv
// Valid/ready channels of the section framing checker: module bytes in, verdicts out.
// Depends on wsfc_pkg for field widths and the status type.
interface wsfc_byte_if;
  import wsfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

interface wsfc_result_if;
  import wsfc_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [ID_W-1:0]   section_id;
  logic [SIZE_W-1:0] section_size;
  logic              size_done;

  modport source (output valid, output status, output section_id, output section_size,
                  output size_done, input ready);
  modport sink   (input valid, input status, input section_id, input section_size,
                  input size_done, output ready);
endinterface

### hw/rtl/wasm_section_framing_checker.sv
// Top level of the WebAssembly section framing checker.
// Depends on wsfc_pkg and the channel interfaces in wsfc_if.sv.

// The checker takes one word (a module byte with its last-byte flag) per clock cycle and
// returns one registered result word for each; it never inserts bubbles
// of its own, so throughput is one byte per cycle and only the downstream ready can slow
// it. The framing-state registers are updated once per accepted byte. The stream must open with
// the 8-byte header 00 61 73 6D 01 00 00 00,
// followed by sections: an id byte no larger than 13, a size in unsigned LEB128 of at
// most five bytes (the fifth byte may carry only its low nibble), and that many payload
// bytes, which are skipped. The first failure latches a distinct status (bad header,
// bad section id, bad size coding) that repeats on every later byte of the module while
// section_id and section_size stay frozen. On the byte flagged last the status reads
// accepted when the module ends right after the header or a complete section, truncated
// when it ends anywhere else without a failure; the checker then rearms for the
// next module. section_size shows the size decoded so far and is final on the byte where
// size_done is high.
module wasm_section_framing_checker (
  input  logic          clk,
  input  logic          rst,
  wsfc_byte_if.sink     data,
  wsfc_result_if.source report
);
  import wsfc_pkg::*;

  // Framing state
  phase_t            phase;
  logic [2:0]        header_position;
  logic [2:0]        shift_count;
  logic [SIZE_W-1:0] size_accumulator;
  logic [SIZE_W-1:0] payload_left;
  logic [ID_W-1:0]   current_section;
  status_t           error_code;

  phase_t            phase_next;
  logic [2:0]        header_position_next;
  logic [2:0]        shift_count_next;
  logic [SIZE_W-1:0] size_accumulator_next;
  logic [SIZE_W-1:0] payload_left_next;
  logic [ID_W-1:0]   current_section_next;
  status_t           error_code_next;

  // Result register
  logic              out_valid;
  status_t           out_status;
  logic [ID_W-1:0]   out_section_id;
  logic [SIZE_W-1:0] out_section_size;
  logic              out_size_done;

  // Per-byte decode
  logic              accept;
  logic              no_error;
  logic              header_match;
  logic              header_end;
  logic              id_bad;
  logic              size_bad;
  logic              size_end;
  logic [SIZE_W-1:0] size_term;
  logic [SIZE_W-1:0] size_sum;
  logic [SIZE_W-1:0] payload_dec;

  // Results of this byte
  logic              done;
  logic              complete;
  status_t           status;

  // Take a new word whenever the result register is empty or being drained
  assign data.ready = !out_valid || report.ready;
  assign accept     = data.valid && data.ready;

  assign no_error     = (error_code == ST_OK);
  assign header_match = (data.byte_value == MAGIC[header_position]);
  assign header_end   = (header_position == 3'd7);
  assign id_bad       = (data.byte_value > MAX_SECTION_ID);
  assign size_bad     = (shift_count >= 3'd5) ||
                        ((shift_count == 3'd4) && (data.byte_value[7:4] != 4'd0));
  assign size_end     = !data.byte_value[7];
  assign size_sum     = size_accumulator | size_term;
  assign payload_dec  = payload_left - SIZE_W'(payload_left != '0);

  // Place the seven LEB128 data bits at the current group; the fifth group keeps the
  // low nibble only, the rest is rejected as bad size coding
  always_comb begin
    unique case (shift_count)
      3'd0:    size_term = SIZE_W'(data.byte_value[6:0]);
      3'd1:    size_term = SIZE_W'(data.byte_value[6:0]) << 7;
      3'd2:    size_term = SIZE_W'(data.byte_value[6:0]) << 14;
      3'd3:    size_term = SIZE_W'(data.byte_value[6:0]) << 21;
      3'd4:    size_term = SIZE_W'(data.byte_value[3:0]) << 28;
      default: size_term = '0;
    endcase
  end

  // Next state of the framing walk
  always_comb begin
    phase_next            = phase;
    header_position_next  = header_position;
    shift_count_next      = shift_count;
    size_accumulator_next = size_accumulator;
    payload_left_next     = payload_left;
    current_section_next  = current_section;
    error_code_next       = error_code;
    if (no_error) begin
      unique case (phase)
        PH_HEADER: begin
          if (!header_match) begin
            error_code_next = ST_BAD_HEADER;
          end else if (header_end) begin
            header_position_next = 3'd0;
            phase_next           = PH_ID;
          end else begin
            header_position_next = header_position + 3'd1;
          end
        end
        PH_ID: begin
          if (id_bad) begin
            error_code_next = ST_BAD_ID;
          end else begin
            current_section_next  = data.byte_value[ID_W-1:0];
            shift_count_next      = 3'd0;
            size_accumulator_next = '0;
            phase_next            = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (size_bad) begin
            error_code_next = ST_BAD_SIZE;
          end else begin
            size_accumulator_next = size_sum;
            shift_count_next      = shift_count + 3'd1;
            if (size_end) begin
              shift_count_next  = 3'd0;
              payload_left_next = size_sum;
              phase_next        = (size_sum == '0) ? PH_ID : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // Skip payload bytes; the section closes when the count runs out
          payload_left_next = payload_dec;
          phase_next        = (payload_dec == '0) ? PH_ID : PH_PAYLOAD;
        end
      endcase
    end
  end

  // Result of this byte
  always_comb begin
    done     = no_error && (phase == PH_SIZE) && !size_bad && size_end;
    complete = no_error &&
               (((phase == PH_HEADER) && header_match && header_end) ||
                (done && (size_sum == '0)) ||
                ((phase == PH_PAYLOAD) && (payload_dec == '0)));
    priority if (error_code_next != ST_OK) begin
      status = error_code_next;
    end else if (data.is_last) begin
      status = complete ? ST_ACCEPT : ST_TRUNC;
    end else begin
      status = ST_OK;
    end
  end

  // Advance the framing state; rearm after the last byte of a module
  always_ff @(posedge clk) begin
    if (rst || (accept && data.is_last)) begin
      phase            <= PH_HEADER;
      header_position  <= 3'd0;
      shift_count      <= 3'd0;
      size_accumulator <= '0;
      payload_left     <= '0;
      current_section  <= '0;
      error_code       <= ST_OK;
    end else if (accept) begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      shift_count      <= shift_count_next;
      size_accumulator <= size_accumulator_next;
      payload_left     <= payload_left_next;
      current_section  <= current_section_next;
      error_code       <= error_code_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status       <= status;
      out_section_id   <= current_section_next;
      out_section_size <= size_accumulator_next;
      out_size_done    <= done;
    end
  end

  assign report.valid        = out_valid;
  assign report.status       = out_status;
  assign report.section_id   = out_section_id;
  assign report.section_size = out_section_size;
  assign report.size_done    = out_size_done;

endmodule
